FILE: hdl/cv4cb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cinepak V4 codebook and block decode package
// Shared constants, request and result types, and color helpers.
// ----------------------------------------------------------------------------
package cv4cb_pkg;

    localparam int CODEBOOK_ENTRIES = 256;
    localparam int CB_AW = (CODEBOOK_ENTRIES > 1) ? $clog2(CODEBOOK_ENTRIES) : 1;
    localparam int CNT_W = 9;
    localparam int PIX_W = 24;
    localparam int ROW_W = 4 * PIX_W;
    localparam int PADDR_W = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BLOCK = 1'b1;

    localparam logic [1:0] REG_STRIP_LEFT   = 2'd0;
    localparam logic [1:0] REG_STRIP_TOP    = 2'd1;
    localparam logic [1:0] REG_STRIP_RIGHT  = 2'd2;
    localparam logic [1:0] REG_STRIP_BOTTOM = 2'd3;

    typedef struct packed {
        logic              operation;
        logic              first;
        logic [7:0]        luma0;
        logic [7:0]        luma1;
        logic [7:0]        luma2;
        logic [7:0]        luma3;
        logic signed [7:0] chroma_u;
        logic signed [7:0] chroma_v;
        logic [7:0]        index_top_left;
        logic [7:0]        index_top_right;
        logic [7:0]        index_bottom_left;
        logic [7:0]        index_bottom_right;
    } t_cb_in;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_of_block;
    } t_cb_out;

    function automatic logic [7:0] clamp255(input logic signed [10:0] x);
        logic [7:0] res;
        if (x < 0) begin
            res = 8'd0;
        end else if (x > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] yuv_to_rgb(input logic [7:0] luma,
                                                   input logic signed [7:0] u,
                                                   input logic signed [7:0] v);
        logic signed [10:0] y_s;
        logic signed [10:0] u_s;
        logic signed [10:0] v_s;
        logic signed [10:0] u_half;
        logic signed [10:0] r_s;
        logic signed [10:0] g_s;
        logic signed [10:0] b_s;
        y_s    = signed'({3'b000, luma});
        u_s    = 11'(u);
        v_s    = 11'(v);
        u_half = (u_s + signed'({10'd0, u[7]})) >>> 1;
        r_s    = y_s + (v_s <<< 1);
        g_s    = y_s - u_half - v_s;
        b_s    = y_s + (u_s <<< 1);
        return {clamp255(r_s), clamp255(g_s), clamp255(b_s)};
    endfunction

endpackage

FILE: hdl/cinepak_v4_codebook_block_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cinepak V4 codebook and block decode
// Loads YUV codebook entries as RGB and expands coded 4x4 blocks to pixels.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (valid/ready). A codebook load is
// converted to four RGB pixels and, while the codebook has a free entry,
// written to one codebook memory row in the cycle it is accepted, so loads
// are taken one per cycle while no block is being expanded. A block request
// produces sixteen pixel results in row-major order, one per cycle while the
// receiver takes them, each carrying its x, y position; last_of_block marks
// the sixteenth. The rate of a block is set by the single read port of the
// codebook memory, which supplies one row per pixel, and the next request is
// accepted in the cycle its last pixel is read. Each pixel passes the memory
// read register, then the output register behind the pixel select. Blocks
// past the strip bottom are accepted and produce nothing.
// When the receiver stalls, the output register holds its result and the
// read pipeline behind it stops; new requests wait until the sequencer frees.
// Reset clears the entry count, the block position, the strip registers and
// all valid flags. The codebook memory is not cleared.
// The strip registers sit on an APB port at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module cinepak_v4_codebook_block_decode
    import cv4cb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_cb_in             i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_cb_out            o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] r_strip_left;
    logic [15:0] r_strip_top;
    logic [15:0] r_strip_right;
    logic [15:0] r_strip_bottom;

    logic [CNT_W-1:0] r_entry_count;
    logic [15:0]      r_block_x;
    logic [15:0]      r_block_y;
    logic             r_past_bottom;

    logic [ROW_W-1:0] r_cb_mem [CODEBOOK_ENTRIES];
    logic [ROW_W-1:0] r_rd_row;

    logic        r_act;
    logic [3:0]  r_k;
    logic [15:0] r_bx;
    logic [15:0] r_by;
    logic [7:0]  r_idx [4];

    logic        r_b_vld;
    logic [15:0] r_b_x;
    logic [15:0] r_b_y;
    logic [1:0]  r_b_p;
    logic        r_b_last;
    logic        r_b_black;

    logic    r_out_vld;
    t_cb_out r_out;

    logic c_load;
    logic b_adv;
    logic issue;
    logic in_ready;
    logic acc;
    logic cfg_wr;

    logic [CNT_W-1:0] ld_count;
    logic             ld_ok;
    logic [ROW_W-1:0] ld_row;

    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic        cur_pb;
    logic [17:0] nx_ext;
    logic [17:0] ny_ext;
    logic [15:0] n_block_x;
    logic [15:0] n_block_y;
    logic        n_past_bottom;

    logic [1:0]  seq_q;
    logic [1:0]  seq_p;
    logic [7:0]  seq_idx;
    logic [PIX_W-1:0] sel_pix;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_STRIP_LEFT:   prdata = {16'd0, r_strip_left};
            REG_STRIP_TOP:    prdata = {16'd0, r_strip_top};
            REG_STRIP_RIGHT:  prdata = {16'd0, r_strip_right};
            REG_STRIP_BOTTOM: prdata = {16'd0, r_strip_bottom};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_left   <= 16'd0;
            r_strip_top    <= 16'd0;
            r_strip_right  <= 16'd0;
            r_strip_bottom <= 16'd0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_STRIP_LEFT:   r_strip_left   <= pwdata[15:0];
                REG_STRIP_TOP:    r_strip_top    <= pwdata[15:0];
                REG_STRIP_RIGHT:  r_strip_right  <= pwdata[15:0];
                REG_STRIP_BOTTOM: r_strip_bottom <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign c_load   = !r_out_vld || i_out_ready;
    assign b_adv    = r_b_vld && c_load;
    assign issue    = r_act && (!r_b_vld || b_adv);
    assign in_ready = !r_act || (issue && (r_k == 4'd15));
    assign acc      = i_in_valid && in_ready;
    assign o_in_ready = in_ready;

    assign ld_count = i_in_data.first ? '0 : r_entry_count;
    assign ld_ok    = ({{(32-CNT_W){1'b0}}, ld_count} < 32'(CODEBOOK_ENTRIES));
    assign ld_row   = {yuv_to_rgb(i_in_data.luma3, i_in_data.chroma_u, i_in_data.chroma_v),
                       yuv_to_rgb(i_in_data.luma2, i_in_data.chroma_u, i_in_data.chroma_v),
                       yuv_to_rgb(i_in_data.luma1, i_in_data.chroma_u, i_in_data.chroma_v),
                       yuv_to_rgb(i_in_data.luma0, i_in_data.chroma_u, i_in_data.chroma_v)};

    assign cur_x  = i_in_data.first ? r_strip_left : r_block_x;
    assign cur_y  = i_in_data.first ? r_strip_top  : r_block_y;
    assign cur_pb = i_in_data.first ? 1'b0 : r_past_bottom;
    assign nx_ext = {2'b00, cur_x} + 18'd4;
    assign ny_ext = {2'b00, cur_y} + 18'd4;

    always_comb begin
        n_block_x     = nx_ext[15:0];
        n_block_y     = cur_y;
        n_past_bottom = 1'b0;
        if ((nx_ext + 18'd1) >= {2'b00, r_strip_right}) begin
            n_block_x = r_strip_left;
            if ((ny_ext + 18'd1) >= {2'b00, r_strip_bottom}) begin
                n_past_bottom = 1'b1;
            end else begin
                n_block_y = ny_ext[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_block_x     <= 16'd0;
            r_block_y     <= 16'd0;
            r_past_bottom <= 1'b0;
        end else if (acc) begin
            if (i_in_data.operation == OP_LOAD) begin
                r_entry_count <= ld_ok ? ld_count + CNT_W'(1) : ld_count;
            end else if (cur_pb) begin
                r_block_x     <= cur_x;
                r_block_y     <= cur_y;
                r_past_bottom <= 1'b1;
            end else begin
                r_block_x     <= n_block_x;
                r_block_y     <= n_block_y;
                r_past_bottom <= n_past_bottom;
            end
        end
    end

    assign seq_q   = {r_k[3], r_k[1]};
    assign seq_p   = {r_k[2], r_k[0]};
    assign seq_idx = r_idx[seq_q];

    always_ff @(posedge i_clk) begin
        if (acc && (i_in_data.operation == OP_LOAD) && ld_ok) begin
            r_cb_mem[ld_count[CB_AW-1:0]] <= ld_row;
        end
        if (issue) begin
            r_rd_row <= r_cb_mem[seq_idx[CB_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_k   <= 4'd0;
        end else if (acc && (i_in_data.operation == OP_BLOCK) && !cur_pb) begin
            r_act <= 1'b1;
            r_k   <= 4'd0;
        end else if (issue) begin
            r_k <= r_k + 4'd1;
            if (r_k == 4'd15) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && (i_in_data.operation == OP_BLOCK) && !cur_pb) begin
            r_bx     <= cur_x;
            r_by     <= cur_y;
            r_idx[0] <= i_in_data.index_top_left;
            r_idx[1] <= i_in_data.index_top_right;
            r_idx[2] <= i_in_data.index_bottom_left;
            r_idx[3] <= i_in_data.index_bottom_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (issue) begin
            r_b_vld <= 1'b1;
        end else if (b_adv) begin
            r_b_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_x     <= r_bx + {14'd0, r_k[1:0]};
            r_b_y     <= r_by + {14'd0, r_k[3:2]};
            r_b_p     <= seq_p;
            r_b_last  <= (r_k == 4'd15);
            r_b_black <= ({24'd0, seq_idx} >= 32'(CODEBOOK_ENTRIES));
        end
    end

    always_comb begin
        case (r_b_p)
            2'd0:    sel_pix = r_rd_row[0*PIX_W +: PIX_W];
            2'd1:    sel_pix = r_rd_row[1*PIX_W +: PIX_W];
            2'd2:    sel_pix = r_rd_row[2*PIX_W +: PIX_W];
            default: sel_pix = r_rd_row[3*PIX_W +: PIX_W];
        endcase
        if (r_b_black) begin
            sel_pix = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (c_load) begin
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out.pixel_x       <= r_b_x;
            r_out.pixel_y       <= r_b_y;
            r_out.red           <= sel_pix[23:16];
            r_out.green         <= sel_pix[15:8];
            r_out.blue          <= sel_pix[7:0];
            r_out.last_of_block <= r_b_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: test/cinepak_v4_codebook_block_decode_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cinepak V4 codebook and block decode testbench
// Loads codebook entries and sends coded blocks under several strip settings,
// with random idle cycles on the request side and random stalls on the pixel
// side. A model of the codebook and the block position predicts
// every pixel, and each pixel that leaves the block is checked field by field.
// ----------------------------------------------------------------------------
module cinepak_v4_codebook_block_decode_tb;
    import cv4cb_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_cb_in              i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_cb_out             o_out_data;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Model of the block.
    logic [23:0] cb_rgb [CODEBOOK_ENTRIES][4];
    logic [8:0]  cb_count   = '0;
    logic [15:0] blk_x      = '0;
    logic [15:0] blk_y      = '0;
    logic        strip_done = 1'b0;
    logic [15:0] strip_left   = '0;
    logic [15:0] strip_top    = '0;
    logic [15:0] strip_right  = '0;
    logic [15:0] strip_bottom = '0;

    t_cb_in  pending_requests [$];
    t_cb_out expected_pixels [$];

    int failures    = 0;
    int cycle_count = 0;
    int in_idle     = 0;
    int in_calm     = 0;
    int out_stall   = 0;
    int out_calm    = 0;
    int gen_count   = 0;
    int gen_filled  = 0;

    cinepak_v4_codebook_block_decode i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] sat8(input int x);
        logic [7:0] res;
        if (x < 0) begin
            res = 8'd0;
        end else if (x > 255) begin
            res = 8'd255;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

    // Idle lengths are mostly zero or short, sometimes long, and a calm stretch
    // now and then has none at all.
    function automatic int next_idle(inout int calm);
        int pick;
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm = $urandom_range(20, 60);
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    task automatic decode_request(input t_cb_in req);
        logic [7:0]  lumas [4];
        logic [7:0]  ents [4];
        logic [23:0] rgb;
        t_cb_out     pix;
        int          u;
        int          v;
        int          lum;
        int          c;
        int          row;
        int          col;
        int          nxt;
        lumas = '{req.luma0, req.luma1, req.luma2, req.luma3};
        ents  = '{req.index_top_left, req.index_top_right,
                  req.index_bottom_left, req.index_bottom_right};
        if (req.operation == OP_LOAD) begin
            if (req.first) begin
                cb_count = '0;
            end
            if (cb_count < CODEBOOK_ENTRIES) begin
                u = int'(req.chroma_u);
                v = int'(req.chroma_v);
                for (c = 0; c < 4; c++) begin
                    lum = int'(lumas[c]);
                    cb_rgb[cb_count[7:0]][c] = {sat8(lum + 2 * v), sat8(lum - u / 2 - v),
                                                sat8(lum + 2 * u)};
                end
                cb_count = cb_count + 9'd1;
            end
        end else begin
            if (req.first) begin
                blk_x      = strip_left;
                blk_y      = strip_top;
                strip_done = 1'b0;
            end
            if (!strip_done) begin
                for (row = 0; row < 4; row++) begin
                    for (col = 0; col < 4; col++) begin
                        c = (row / 2) * 2 + col / 2;
                        if (ents[c] < CODEBOOK_ENTRIES) begin
                            rgb = cb_rgb[ents[c]][(row % 2) * 2 + col % 2];
                        end else begin
                            rgb = '0;
                        end
                        pix.pixel_x       = 16'(blk_x + col);
                        pix.pixel_y       = 16'(blk_y + row);
                        pix.red           = rgb[23:16];
                        pix.green         = rgb[15:8];
                        pix.blue          = rgb[7:0];
                        pix.last_of_block = (row == 3) && (col == 3);
                        expected_pixels.push_back(pix);
                    end
                end
                nxt = int'(blk_x) + 4;
                if (nxt + 1 >= int'(strip_right)) begin
                    blk_x = strip_left;
                    nxt   = int'(blk_y) + 4;
                    if (nxt + 1 >= int'(strip_bottom)) begin
                        strip_done = 1'b1;
                    end else begin
                        blk_y = 16'(nxt);
                    end
                end else begin
                    blk_x = 16'(nxt);
                end
            end
        end
    endtask

    task automatic compare_pixel(input t_cb_out got);
        t_cb_out want;
        if (expected_pixels.size() == 0) begin
            $error("unexpected pixel at x %0d, y %0d", got.pixel_x, got.pixel_y);
            failures++;
            return;
        end
        want = expected_pixels.pop_front();
        if (got.pixel_x !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
            failures++;
        end
        if (got.pixel_y !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
            failures++;
        end
        if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            failures++;
        end
        if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            failures++;
        end
        if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            failures++;
        end
        if (got.last_of_block !== want.last_of_block) begin
            $error("last_of_block: expected %0d, got %0d", want.last_of_block,
                   got.last_of_block);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_request(i_in_data);
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_idle > 0) begin
                    in_idle = in_idle - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    i_in_data  <= pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                    in_idle = next_idle(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                compare_pixel(o_out_data);
            end
            if (out_stall > 0) begin
                out_stall = out_stall - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                out_stall = next_idle(out_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One APB transfer; a write also updates the model, a read is checked.
    task automatic apb_access(input logic is_write, input logic [1:0] regi,
                              input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= PADDR_W'({regi, 2'b00});
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) begin
            @(negedge i_clk);
        end
        if (!is_write && prdata[15:0] !== value) begin
            $error("register %0d readback: expected %0d, got %0d", regi, value,
                   prdata[15:0]);
            failures++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (is_write) begin
            case (regi)
                REG_STRIP_LEFT: begin
                    strip_left = value;
                end
                REG_STRIP_TOP: begin
                    strip_top = value;
                end
                REG_STRIP_RIGHT: begin
                    strip_right = value;
                end
                default: begin
                    strip_bottom = value;
                end
            endcase
        end
    endtask

    task automatic set_strip(input logic [15:0] left, input logic [15:0] top,
                             input logic [15:0] right, input logic [15:0] bottom);
        apb_access(1'b1, REG_STRIP_LEFT, left);
        apb_access(1'b1, REG_STRIP_TOP, top);
        apb_access(1'b1, REG_STRIP_RIGHT, right);
        apb_access(1'b1, REG_STRIP_BOTTOM, bottom);
        apb_access(1'b0, REG_STRIP_LEFT, left);
        apb_access(1'b0, REG_STRIP_TOP, top);
        apb_access(1'b0, REG_STRIP_RIGHT, right);
        apb_access(1'b0, REG_STRIP_BOTTOM, bottom);
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_requests.size() != 0 || i_in_valid ||
                   expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_cb_in random_request();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(t_cb_in)-1:0];
    endfunction

    function automatic logic [7:0] written_index();
        return 8'($urandom_range(0, gen_filled - 1));
    endfunction

    // Block requests only ever name entries that a load has already written,
    // and loads always fill the codebook upward from entry zero.
    task automatic add_request(input t_cb_in req);
        if (req.operation == OP_BLOCK) begin
            req.index_top_left     = (req.index_top_left < gen_filled) ?
                                     req.index_top_left : written_index();
            req.index_top_right    = (req.index_top_right < gen_filled) ?
                                     req.index_top_right : written_index();
            req.index_bottom_left  = (req.index_bottom_left < gen_filled) ?
                                     req.index_bottom_left : written_index();
            req.index_bottom_right = (req.index_bottom_right < gen_filled) ?
                                     req.index_bottom_right : written_index();
        end else begin
            if (req.first) begin
                gen_count = 0;
            end
            if (gen_count < CODEBOOK_ENTRIES) begin
                gen_count++;
                if (gen_count > gen_filled) begin
                    gen_filled = gen_count;
                end
            end
        end
        pending_requests.push_back(req);
    endtask

    task automatic add_load(input logic first, input logic [7:0] l0, input logic [7:0] l1,
                            input logic [7:0] l2, input logic [7:0] l3,
                            input logic [7:0] u, input logic [7:0] v);
        t_cb_in req;
        req           = random_request();
        req.operation = OP_LOAD;
        req.first     = first;
        req.luma0     = l0;
        req.luma1     = l1;
        req.luma2     = l2;
        req.luma3     = l3;
        req.chroma_u  = u;
        req.chroma_v  = v;
        add_request(req);
    endtask

    task automatic add_block(input logic first, input logic [7:0] tl, input logic [7:0] tr,
                             input logic [7:0] bl, input logic [7:0] br);
        t_cb_in req;
        req                    = random_request();
        req.operation          = OP_BLOCK;
        req.first              = first;
        req.index_top_left     = tl;
        req.index_top_right    = tr;
        req.index_bottom_left  = bl;
        req.index_bottom_right = br;
        add_request(req);
    endtask

    task automatic add_random_load(input logic first);
        add_load(first, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
    endtask

    task automatic add_random_block(input logic first);
        add_block(first, written_index(), written_index(), written_index(),
                  written_index());
    endtask

    // Mostly well-formed runs of blocks and loads, with single noise requests.
    task automatic random_traffic(input int count);
        t_cb_in req;
        int     done;
        int     len;
        int     kind;
        int     k;
        done = 0;
        while (done < count) begin
            kind = $urandom_range(0, 9);
            len  = 1;
            if (kind < 4) begin
                len = $urandom_range(2, 8);
                for (k = 0; k < len; k++) begin
                    add_random_block(k == 0);
                end
            end else if (kind < 6) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    add_random_load(k == 0);
                end
            end else if (kind < 8) begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++) begin
                    add_random_load(1'b0);
                end
            end else begin
                req = random_request();
                add_request(req);
            end
            done += len;
        end
    endtask

    initial begin
        int k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Strip registers at their reset value of zero: every block run ends
        // after its first block.
        @(negedge i_clk);
        add_load(1'b1, 8'd0, 8'd255, 8'd0, 8'd255, 8'h80, 8'h80);
        add_load(1'b0, 8'd255, 8'd0, 8'd255, 8'd0, 8'h7f, 8'h7f);
        add_load(1'b0, 8'd128, 8'd64, 8'd200, 8'd10, 8'hff, 8'h01);
        add_load(1'b0, 8'd90, 8'd91, 8'd92, 8'd93, 8'hfd, 8'h00);
        add_load(1'b0, 8'd0, 8'd0, 8'd255, 8'd255, 8'h03, 8'hff);
        add_block(1'b1, 8'd0, 8'd1, 8'd2, 8'd3);
        add_block(1'b0, 8'd3, 8'd2, 8'd1, 8'd0);
        add_block(1'b1, 8'd4, 8'd3, 8'd2, 8'd1);
        add_load(1'b1, 8'd17, 8'd240, 8'd128, 8'd1, 8'h80, 8'h7f);
        add_block(1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
        add_load(1'b0, 8'd254, 8'd3, 8'd77, 8'd160, 8'h7f, 8'h80);
        add_block(1'b1, 8'd1, 8'd0, 8'd1, 8'd0);
        add_block(1'b0, 8'd2, 8'd2, 8'd2, 8'd2);
        wait_idle();

        // Fill the whole codebook and run past its end, then walk one strip
        // of four by four blocks and beyond its bottom.
        set_strip(16'd0, 16'd0, 16'd16, 16'd16);
        @(negedge i_clk);
        add_random_load(1'b1);
        for (k = 0; k < 259; k++) begin
            add_random_load(1'b0);
        end
        add_random_block(1'b1);
        for (k = 0; k < 17; k++) begin
            add_random_block(1'b0);
        end
        wait_idle();

        set_strip(16'hfffe, 16'hfffd, 16'hffff, 16'hffff);
        @(negedge i_clk);
        random_traffic(10);
        wait_idle();

        set_strip(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        @(negedge i_clk);
        random_traffic(10);
        wait_idle();

        set_strip(16'h0000, 16'h0000, 16'hffff, 16'hffff);
        @(negedge i_clk);
        random_traffic(10);
        wait_idle();

        set_strip(16'd100, 16'd40, 16'd20, 16'd30);
        @(negedge i_clk);
        random_traffic(10);
        wait_idle();

        repeat (2) begin
            strip_left = 16'($urandom_range(0, 65535));
            strip_top  = 16'($urandom_range(0, 65535));
            set_strip(strip_left, strip_top, 16'(strip_left + $urandom_range(1, 24)),
                      16'(strip_top + $urandom_range(1, 24)));
            @(negedge i_clk);
            random_traffic(10);
            wait_idle();
        end

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
